### hw/rtl/spq_pkg.sv
package spq_pkg;

  localparam int unsigned DEPTH  = 16;
  localparam int unsigned IDX_W  = $clog2(DEPTH);
  localparam int unsigned OCC_W  = $clog2(DEPTH + 1);
  localparam int unsigned TAG_W  = 32;
  localparam int unsigned PRI_W  = 8;
  localparam int unsigned FILL_W = 5;

  typedef enum logic {
    CMD_ENQUEUE = 1'b0,
    CMD_DEQUEUE = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_RESP
  } ctrl_state_e;

  typedef struct packed {
    cmd_e             command;
    logic [TAG_W-1:0] item_tag;
    logic [PRI_W-1:0] priority_req;
  } spq_in_t;

  typedef struct packed {
    status_e           status;
    logic [TAG_W-1:0]  head_tag;
    logic [PRI_W-1:0]  head_priority;
    logic [FILL_W-1:0] fill_level;
  } spq_out_t;

  typedef struct packed {
    logic [PRI_W-1:0] pri;
    logic [TAG_W-1:0] tag;
  } spq_entry_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;  // capture the incoming transaction
    logic exec;  // apply it to the sorted list and register the result
  } spq_ctl_t;

endpackage

### hw/rtl/spq_ctrl.sv
module spq_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  output logic              valid_o,
  output spq_pkg::spq_ctl_t ctl_o
);
  import spq_pkg::*;

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    busy_o     = 1'b0;
    valid_o    = 1'b0;
    ctl_o.load = 1'b0;
    ctl_o.exec = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          ctl_o.load = 1'b1;
          state_d    = S_EXEC;
        end
      end
      S_EXEC: begin
        busy_o     = 1'b1;
        ctl_o.exec = 1'b1;
        state_d    = S_RESP;
      end
      S_RESP: begin
        // Result is on the port; take the next transaction alongside it.
        valid_o = 1'b1;
        if (start_i) begin
          ctl_o.load = 1'b1;
          state_d    = S_EXEC;
        end else begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

`ifndef SYNTH
  a_resp_after_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RESP) |-> $past(state_q == S_EXEC))
    else $error("response without a preceding execute cycle");

  a_exec_after_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_o.load |=> (state_q == S_EXEC))
    else $error("loaded transaction not executed");

  a_no_load_when_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_o |-> !ctl_o.load)
    else $error("load while busy");
`endif

endmodule

### hw/rtl/spq_datapath.sv
module spq_datapath (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  spq_pkg::spq_ctl_t ctl_i,
  input  spq_pkg::spq_in_t  req_i,
  output spq_pkg::spq_out_t rsp_o
);
  import spq_pkg::*;

  spq_in_t    req_q;
  spq_out_t   rsp_q, rsp_d;
  spq_entry_t slot_q [DEPTH];
  spq_entry_t slot_d [DEPTH];
  logic [OCC_W-1:0] occ_q, occ_d;

  logic [DEPTH-1:0] keep;       // slot holds an entry not greater than the new one
  logic [DEPTH-1:0] ins_here;   // first slot after the kept prefix
  logic             full, empty;
  logic             do_enq, do_deq;
  spq_entry_t       new_entry;

  assign full      = (occ_q == OCC_W'(DEPTH));
  assign empty     = (occ_q == '0);
  assign do_enq    = (req_q.command == CMD_ENQUEUE) && !full;
  assign do_deq    = (req_q.command == CMD_DEQUEUE) && !empty;
  assign new_entry = '{pri: req_q.priority_req, tag: req_q.item_tag};

  // Parallel compare and shift: every slot decides its next value locally.
  for (genvar k = 0; k < DEPTH; k++) begin : g_slot
    assign keep[k] = (occ_q > OCC_W'(k)) && (slot_q[k].pri <= req_q.priority_req);

    if (k == 0) begin : g_head
      assign ins_here[k] = !keep[k];
    end else begin : g_body
      assign ins_here[k] = !keep[k] && keep[k-1];
    end

    always_comb begin
      slot_d[k] = slot_q[k];
      if (do_enq && !keep[k]) begin
        if (ins_here[k]) begin
          slot_d[k] = new_entry;
        end else if (k > 0) begin
          slot_d[k] = slot_q[(k > 0) ? k - 1 : 0];
        end
      end else if (do_deq && (k < DEPTH - 1)) begin
        slot_d[k] = slot_q[(k < DEPTH - 1) ? k + 1 : k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (ctl_i.exec) begin
        slot_q[k] <= slot_d[k];
      end
    end
  end

  always_comb begin
    occ_d = occ_q;
    rsp_d = '0;
    unique case (req_q.command)
      CMD_ENQUEUE: begin
        if (full) begin
          rsp_d.status = ST_FULL;
        end else begin
          occ_d        = occ_q + 1'b1;
          rsp_d.status = ST_DONE;
        end
      end
      CMD_DEQUEUE: begin
        if (empty) begin
          rsp_d.status = ST_EMPTY;
        end else begin
          occ_d               = occ_q - 1'b1;
          rsp_d.status        = ST_DONE;
          rsp_d.head_tag      = slot_q[0].tag;
          rsp_d.head_priority = slot_q[0].pri;
        end
      end
      default: begin
        rsp_d.status = ST_DONE;
      end
    endcase
    rsp_d.fill_level = FILL_W'(occ_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= '0;
    end else if (ctl_i.exec) begin
      occ_q <= occ_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      req_q <= req_i;
    end
    if (ctl_i.exec) begin
      rsp_q <= rsp_d;
    end
  end

  assign rsp_o = rsp_q;

`ifndef SYNTH
  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= OCC_W'(DEPTH))
    else $error("occupancy beyond depth");

  a_enq_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl_i.exec && do_enq) |=> (occ_q == $past(occ_q) + 1'b1))
    else $error("enqueue did not add one entry");

  a_deq_shrinks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl_i.exec && do_deq) |=> (occ_q == $past(occ_q) - 1'b1))
    else $error("dequeue did not remove one entry");

  a_reject_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl_i.exec && !do_enq && !do_deq) |=> (occ_q == $past(occ_q)))
    else $error("rejected transaction changed occupancy");
`endif

endmodule

### hw/rtl/stable_priority_queue.sv
// Channel   Handshake                   Payload
// --------  --------------------------  ------------------------------------------
// request   start high, busy low        req_i : command, item_tag, priority_req
// response  valid_o high for one cycle  rsp_o : status, head_tag, head_priority,
//                                               fill_level
//
// Each transaction passes through the execute cycle, in which all slots compare
// against the new priority and shift in parallel, and then the response cycle.
// A new transaction is taken during the response cycle, so requests and
// responses overlap; busy is high only in the execute cycle.
// Reset (rst_ni, asynchronous, active low) empties the queue and idles the
// controller; slot contents are left as they are and never read before written.
// The receiver cannot stall: each response is presented once and must be taken.
module stable_priority_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  spq_pkg::spq_in_t  req_i,
  output logic              valid_o,
  output spq_pkg::spq_out_t rsp_o
);
  import spq_pkg::*;

  spq_ctl_t ctl;

  // Sequence load, execute and respond for each transaction.
  spq_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .busy_o  (busy),
    .valid_o (valid_o),
    .ctl_o   (ctl)
  );

  // Hold the sorted list, occupancy and the registered response.
  spq_datapath u_datapath (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (ctl),
    .req_i  (req_i),
    .rsp_o  (rsp_o)
  );

endmodule

### verif/spq_order_checker.sv
module spq_order_checker (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic              busy_i,
  input  spq_pkg::spq_in_t  req_i,
  input  logic              valid_i,
  input  spq_pkg::spq_out_t rsp_i,
  output int                fail_count_o,
  output int                pending_o
);
  import spq_pkg::*;

  // Shadow copy of the sorted list; slot 0 is the head.
  spq_entry_t  shadow_slots [DEPTH];
  int unsigned shadow_held;
  spq_out_t    expected_rsp_q [$];

  // Apply one transaction to the shadow list and return its response.
  function automatic spq_out_t predict_queue_response(spq_in_t req);
    spq_out_t rsp;
    int unsigned pos;
    int unsigned k;
    rsp = '0;
    rsp.status = ST_DONE;
    if (req.command == CMD_ENQUEUE) begin
      if (shadow_held >= DEPTH) begin
        rsp.status = ST_FULL;
      end else begin
        // Stable insert: go after every entry whose priority is not greater.
        pos = 0;
        while (pos < shadow_held && shadow_slots[pos].pri <= req.priority_req) pos++;
        for (k = shadow_held; k > pos; k--) shadow_slots[k] = shadow_slots[k-1];
        shadow_slots[pos].pri = req.priority_req;
        shadow_slots[pos].tag = req.item_tag;
        shadow_held++;
      end
    end else if (shadow_held == 0) begin
      rsp.status = ST_EMPTY;
    end else begin
      rsp.head_tag      = shadow_slots[0].tag;
      rsp.head_priority = shadow_slots[0].pri;
      for (k = 1; k < shadow_held; k++) shadow_slots[k-1] = shadow_slots[k];
      shadow_held--;
    end
    rsp.fill_level = FILL_W'(shadow_held);
    return rsp;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    spq_out_t exp_rsp;
    bit       bad;
    if (!rst_ni) begin
      shadow_held = 0;
      expected_rsp_q.delete();
      fail_count_o = 0;
      pending_o = 0;
    end else begin
      if (valid_i) begin
        if (expected_rsp_q.size() == 0) begin
          $display("%0t: unexpected response %p", $time, rsp_i);
          fail_count_o++;
        end else begin
          exp_rsp = expected_rsp_q.pop_front();
          bad = 1'b0;
          if (rsp_i.status !== exp_rsp.status) begin
            $display("%0t: status expected %0d actual %0d", $time, exp_rsp.status,
                     rsp_i.status);
            bad = 1'b1;
          end
          if (rsp_i.head_tag !== exp_rsp.head_tag) begin
            $display("%0t: head_tag expected %h actual %h", $time, exp_rsp.head_tag,
                     rsp_i.head_tag);
            bad = 1'b1;
          end
          if (rsp_i.head_priority !== exp_rsp.head_priority) begin
            $display("%0t: head_priority expected %0d actual %0d", $time,
                     exp_rsp.head_priority, rsp_i.head_priority);
            bad = 1'b1;
          end
          if (rsp_i.fill_level !== exp_rsp.fill_level) begin
            $display("%0t: fill_level expected %0d actual %0d", $time, exp_rsp.fill_level,
                     rsp_i.fill_level);
            bad = 1'b1;
          end
          if (bad) fail_count_o++;
        end
      end
      if (start_i && !busy_i) expected_rsp_q.push_back(predict_queue_response(req_i));
      pending_o = expected_rsp_q.size();
    end
  end

endmodule

### verif/tb_stable_priority_queue.sv
module tb_stable_priority_queue;
  import spq_pkg::*;

  // Give up after this many cycles with no transaction on either channel.
  localparam int unsigned STALL_LIMIT = 1000;
  localparam int unsigned PHASES      = 8;
  localparam int unsigned PHASE_ITEMS = 100;

  logic     clk_i;
  logic     rst_ni;
  logic     start;
  logic     busy;
  spq_in_t  req_i;
  logic     valid_o;
  spq_out_t rsp_o;
  int       fail_count;
  int       pending;
  int unsigned quiet_cycles;

  stable_priority_queue u_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .busy    (busy),
    .req_i   (req_i),
    .valid_o (valid_o),
    .rsp_o   (rsp_o)
  );

  // Watch both channels, keep the shadow list and compare every response.
  spq_order_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start),
    .busy_i       (busy),
    .req_i        (req_i),
    .valid_i      (valid_o),
    .rsp_i        (rsp_o),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Watchdog: count cycles in which neither a request nor a response moves.
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || valid_o) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // Idle cycles ahead of the next request; zero when idling is switched off.
  function automatic int unsigned draw_gap(bit idle_on);
    return idle_on ? $urandom_range(10, 0) : 0;
  endfunction

  // Issue one transaction. Inputs move only at the falling edge; busy only
  // changes on a rising edge, so its value here holds through the next edge.
  // Keep start high across back-to-back requests instead of re-raising it.
  task automatic send_request(input cmd_e cmd, input logic [TAG_W-1:0] tag,
                              input logic [PRI_W-1:0] pri, input int unsigned gap);
    if (gap > 0) begin
      @(negedge clk_i);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    start                <= 1'b1;
    req_i.command        <= cmd;
    req_i.item_tag       <= tag;
    req_i.priority_req   <= pri;
    while (busy) @(negedge clk_i);
    // The transaction is taken at this edge.
    @(posedge clk_i);
  endtask

  // Hold off the sender until every outstanding response has come back.
  task automatic drain_responses();
    @(negedge clk_i);
    start <= 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  // Priority drawn according to the phase: full range, a narrow band that
  // forces many ties, or mostly the two extremes.
  function automatic logic [PRI_W-1:0] draw_priority(int unsigned mode);
    case (mode)
      0: begin
        return PRI_W'($urandom_range(255, 0));
      end
      1: begin
        return PRI_W'($urandom_range(3, 0));
      end
      default: begin
        case ($urandom_range(3, 0))
          0: return '0;
          1: return '1;
          2: return PRI_W'($urandom_range(2, 0));
          default: return PRI_W'($urandom_range(255, 253));
        endcase
      end
    endcase
  endfunction

  initial begin
    int unsigned enq_pct [PHASES];
    int unsigned phase;
    int unsigned n;
    bit          idle_on;
    cmd_e        cmd;

    enq_pct = '{80, 20, 55, 95, 5, 50, 70, 30};

    // Drive every input to a known value before the first edge.
    rst_ni = 1'b0;
    start  = 1'b0;
    req_i  = '0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part: dequeue on an empty queue first.
    send_request(CMD_DEQUEUE, $urandom(), PRI_W'($urandom()), draw_gap(1'b1));
    // Extremes of tag and priority.
    send_request(CMD_ENQUEUE, '0, 8'd200, draw_gap(1'b1));
    send_request(CMD_ENQUEUE, '1, '1, draw_gap(1'b1));
    // Smaller than the head with two entries held: must become the head.
    send_request(CMD_ENQUEUE, 32'hA5A5_0001, 8'd100, draw_gap(1'b1));
    // Equal priority: must go after the entry already there.
    send_request(CMD_ENQUEUE, 32'hA5A5_0002, 8'd100, draw_gap(1'b1));
    send_request(CMD_ENQUEUE, 32'h5A5A_0003, '0, draw_gap(1'b1));
    send_request(CMD_ENQUEUE, 32'h5A5A_0004, '0, draw_gap(1'b0));
    // Fill up to the limit, then push against a full queue at both extremes.
    for (n = 0; n < DEPTH - 6; n++)
      send_request(CMD_ENQUEUE, $urandom(), draw_priority(2), draw_gap(n[0]));
    send_request(CMD_ENQUEUE, 32'hDEAD_0000, '0, draw_gap(1'b0));
    send_request(CMD_ENQUEUE, 32'hDEAD_FFFF, '1, draw_gap(1'b1));
    for (n = 0; n < 3; n++)
      send_request(CMD_DEQUEUE, $urandom(), PRI_W'($urandom()), draw_gap(1'b1));
    drain_responses();

    // Random part: phases with different enqueue mix so the queue swings
    // between empty and full; odd phases run with no idle cycles at all.
    for (phase = 0; phase < PHASES; phase++) begin
      idle_on = (phase % 2 == 0);
      for (n = 0; n < PHASE_ITEMS; n++) begin
        cmd = ($urandom_range(99, 0) < enq_pct[phase]) ? CMD_ENQUEUE : CMD_DEQUEUE;
        send_request(cmd, $urandom(), draw_priority(phase % 3), draw_gap(idle_on));
      end
      // Pause the sender until the block has answered everything.
      drain_responses();
    end

    // Allow the response pipeline to settle before the verdict.
    repeat (6) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
